@@ rtl/core/tcst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared types and constants of the TCP connection state tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned FLAGS_W     = 8;
	localparam int unsigned STATE_W     = 4;
	localparam int unsigned DIR_W       = 2;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [FLAGS_W-1:0] TH_FIN  = 8'h01;
	localparam logic [FLAGS_W-1:0] TH_SYN  = 8'h02;
	localparam logic [FLAGS_W-1:0] TH_RST  = 8'h04;
	localparam logic [FLAGS_W-1:0] TH_PUSH = 8'h08;
	localparam logic [FLAGS_W-1:0] TH_ACK  = 8'h10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CLIENT_ADDR = 1'b0,
		CFG_SERVER_ADDR = 1'b1
	} cfg_index_t;

	typedef enum logic [STATE_W-1:0] {
		ST_LISTEN      = 4'd0,
		ST_SYN_SENT    = 4'd1,
		ST_SYN_RCVD    = 4'd2,
		ST_ESTABLISHED = 4'd3,
		ST_FIN_WAIT_1  = 4'd4,
		ST_FIN_WAIT_2  = 4'd5,
		ST_CLOSE_WAIT  = 4'd6,
		ST_LAST_ACK    = 4'd7,
		ST_TIME_WAIT   = 4'd8,
		ST_CLOSED      = 4'd9
	} tcp_state_t;

	typedef enum logic [DIR_W-1:0] {
		PKT_UNRELATED   = 2'd0,
		PKT_FROM_CLIENT = 2'd1,
		PKT_FROM_SERVER = 2'd2
	} dir_t;

	// A classified packet as it travels from the front end to the back end.
	typedef struct packed {
		dir_t               dir;
		logic [FLAGS_W-1:0] flags;
	} pkt_word_t;

endpackage

`default_nettype wire

@@ rtl/core/tcst_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcst_front
// Holds the endpoint address registers and classifies each packet's direction.
// ----------------------------------------------------------------------------
module tcst_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tcst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcst_pkg::ADDR_W-1:0] cfg_data,
	input  wire logic [tcst_pkg::ADDR_W-1:0] src_addr,
	input  wire logic [tcst_pkg::ADDR_W-1:0] dst_addr,
	input  wire logic [tcst_pkg::FLAGS_W-1:0] flags,
	output tcst_pkg::pkt_word_t              word
);
	import tcst_pkg::*;

	logic [ADDR_W-1:0] client_addr_q;
	logic [ADDR_W-1:0] server_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_addr_q <= '0;
			server_addr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CLIENT_ADDR: client_addr_q <= cfg_data;
				CFG_SERVER_ADDR: server_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// When both addresses are equal, the client match wins.
	always_comb begin
		word.flags = flags;
		priority if (src_addr == client_addr_q && dst_addr == server_addr_q) begin
			word.dir = PKT_FROM_CLIENT;
		end else if (dst_addr == client_addr_q && src_addr == server_addr_q) begin
			word.dir = PKT_FROM_SERVER;
		end else begin
			word.dir = PKT_UNRELATED;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tcst_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcst_queue
// Short queue of classified packet words between the front and back ends.
// ----------------------------------------------------------------------------
module tcst_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  tcst_pkg::pkt_word_t     push_word,
	output logic                    full,
	input  wire logic               pop,
	output tcst_pkg::pkt_word_t     head_word,
	output logic                    not_empty
);
	import tcst_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	pkt_word_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_word = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tcst_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcst_back
// Applies the connection transition table and holds the result register.
// ----------------------------------------------------------------------------
module tcst_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         word_valid,
	input  tcst_pkg::pkt_word_t               word,
	output logic                              word_take,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [tcst_pkg::STATE_W-1:0]      client_side_state,
	output logic [tcst_pkg::STATE_W-1:0]      server_side_state,
	output logic [tcst_pkg::DIR_W-1:0]        packet_direction,
	output logic [tcst_pkg::DIR_W-1:0]        last_fin_direction
);
	import tcst_pkg::*;

	tcp_state_t client_q;
	tcp_state_t server_q;
	dir_t       fin_dir_q;
	logic       out_valid_q;
	dir_t       dir_q;

	tcp_state_t client_nx;
	tcp_state_t server_nx;
	dir_t       fin_dir_nx;

	logic [FLAGS_W-1:0] f;
	logic has_syn;
	logic has_rst;
	logic has_ack;

	assign word_take = word_valid && (!out_valid_q || out_ready);

	assign f       = word.flags;
	assign has_syn = (f & TH_SYN) != '0;
	assign has_rst = (f & TH_RST) != '0;
	assign has_ack = (f & TH_ACK) != '0;

	always_comb begin
		client_nx  = client_q;
		server_nx  = server_q;
		fin_dir_nx = (f == TH_FIN) ? word.dir : fin_dir_q;
		unique case (word.dir)
			PKT_FROM_SERVER: begin
				// Server packets are keyed on the client side's state.
				unique case (client_q)
					ST_SYN_SENT: begin
						if (f == (TH_SYN | TH_ACK)) begin
							client_nx = ST_ESTABLISHED;
						end else if (f == TH_RST) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end
					end
					ST_ESTABLISHED: begin
						if (f == (TH_FIN | TH_ACK) || f == (TH_FIN | TH_ACK | TH_PUSH)
								|| f == TH_FIN) begin
							client_nx = ST_CLOSE_WAIT;
							server_nx = ST_FIN_WAIT_1;
						end else if (f == TH_RST) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end
					end
					ST_FIN_WAIT_1: begin
						if (f == TH_RST) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end else if (f == (TH_FIN | TH_ACK)) begin
							client_nx = ST_FIN_WAIT_2;
							server_nx = ST_LAST_ACK;
						end else if (f == TH_ACK) begin
							client_nx = ST_FIN_WAIT_2;
							server_nx = ST_CLOSE_WAIT;
						end
					end
					ST_FIN_WAIT_2: begin
						if (f == (TH_FIN | TH_ACK) || f == TH_FIN) begin
							client_nx = ST_TIME_WAIT;
							server_nx = ST_LAST_ACK;
						end
					end
					ST_LAST_ACK: begin
						if (f == TH_ACK) begin
							client_nx = ST_CLOSED;
						end
					end
					ST_CLOSE_WAIT: begin
						if (f == TH_RST) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end else if (f == (TH_ACK | TH_PUSH | TH_FIN)) begin
							client_nx = ST_LAST_ACK;
							server_nx = ST_FIN_WAIT_2;
						end else if (f == TH_ACK) begin
							server_nx = ST_FIN_WAIT_2;
						end
					end
					default: ;
				endcase
			end
			PKT_FROM_CLIENT: begin
				// Client packets are keyed on the server side's state.
				unique case (server_q)
					ST_LISTEN: begin
						if (has_syn && !has_rst) begin
							client_nx = ST_SYN_SENT;
							server_nx = ST_SYN_RCVD;
						end
					end
					ST_SYN_RCVD: begin
						if (has_rst) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end else if (has_ack) begin
							server_nx = ST_ESTABLISHED;
						end
					end
					ST_ESTABLISHED: begin
						if (f == (TH_FIN | TH_ACK)) begin
							client_nx = ST_FIN_WAIT_1;
							server_nx = ST_CLOSE_WAIT;
						end else if (f == (TH_FIN | TH_ACK | TH_PUSH)) begin
							client_nx = ST_CLOSE_WAIT;
							server_nx = ST_FIN_WAIT_1;
						end else if (has_rst) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end
					end
					ST_LAST_ACK: begin
						if (has_ack) begin
							server_nx = ST_CLOSED;
						end
					end
					ST_FIN_WAIT_1: begin
						if (f == (TH_ACK | TH_FIN)) begin
							client_nx = ST_LAST_ACK;
							server_nx = ST_FIN_WAIT_2;
						end else if (has_rst) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end else if (f == TH_ACK) begin
							client_nx = ST_CLOSE_WAIT;
							server_nx = ST_FIN_WAIT_2;
						end
					end
					ST_FIN_WAIT_2: begin
						if (f == (TH_FIN | TH_ACK) || f == TH_FIN) begin
							client_nx = ST_LAST_ACK;
							server_nx = ST_TIME_WAIT;
						end
					end
					ST_CLOSE_WAIT: begin
						if (f == TH_RST) begin
							client_nx = ST_CLOSED;
							server_nx = ST_CLOSED;
						end else if (has_ack) begin
							client_nx = ST_FIN_WAIT_2;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_q    <= ST_LISTEN;
			server_q    <= ST_LISTEN;
			fin_dir_q   <= PKT_UNRELATED;
			out_valid_q <= 1'b0;
		end else begin
			if (word_take) begin
				client_q  <= client_nx;
				server_q  <= server_nx;
				fin_dir_q <= fin_dir_nx;
			end
			if (word_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_take) begin
			dir_q <= word.dir;
		end
	end

	// The state registers double as the result register for both sides.
	assign out_valid          = out_valid_q;
	assign client_side_state  = client_q;
	assign server_side_state  = server_q;
	assign packet_direction   = dir_q;
	assign last_fin_direction = fin_dir_q;

endmodule

`default_nettype wire

@@ rtl/core/tcp_connection_state_tracker_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_connection_state_tracker_core
// Tracks the client-side and server-side TCP states of one connection.
// ----------------------------------------------------------------------------
// Packet headers enter on the input channel (in_valid/in_ready): source and
// destination IPv4 address and the TCP flag byte. Each word yields one result
// word on the output channel (out_valid/out_ready): both side states after the
// update, the packet's direction and the direction of the latest bare FIN.
// The endpoint addresses are written through the cfg channel (index 0 client,
// index 1 server); cfg_ready is always high, and writes belong in idle time.
// The front end compares addresses and pushes the classified word into a
// two-entry queue; the back end pops one word a cycle into the table update
// while the receiver takes results. A result passes through the queue entry
// and then the state registers, and one word per cycle is sustained while
// out_ready stays high. When the receiver stalls, the result register holds
// and the queue fills; in_ready drops only once both queue entries are taken.
// Reset clears the addresses to zero, both states to LISTEN and the recorded
// FIN direction to none; the queue and result register come up empty.
// ----------------------------------------------------------------------------
module tcp_connection_state_tracker_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tcst_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tcst_pkg::ADDR_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [tcst_pkg::ADDR_W-1:0]       pkt_src_addr,
	input  wire logic [tcst_pkg::ADDR_W-1:0]       pkt_dst_addr,
	input  wire logic [tcst_pkg::FLAGS_W-1:0]      tcp_flags,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [tcst_pkg::STATE_W-1:0]           client_side_state,
	output logic [tcst_pkg::STATE_W-1:0]           server_side_state,
	output logic [tcst_pkg::DIR_W-1:0]             packet_direction,
	output logic [tcst_pkg::DIR_W-1:0]             last_fin_direction
);
	import tcst_pkg::*;

	pkt_word_t front_word;
	pkt_word_t head_word;
	logic      queue_full;
	logic      queue_not_empty;
	logic      queue_pop;
	logic      queue_push;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !queue_full;
	assign queue_push = in_valid && !queue_full;

	tcst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_addr  (pkt_src_addr),
		.dst_addr  (pkt_dst_addr),
		.flags     (tcp_flags),
		.word      (front_word)
	);

	tcst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (queue_push),
		.push_word (front_word),
		.full      (queue_full),
		.pop       (queue_pop),
		.head_word (head_word),
		.not_empty (queue_not_empty)
	);

	tcst_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.word_valid         (queue_not_empty),
		.word               (head_word),
		.word_take          (queue_pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.client_side_state  (client_side_state),
		.server_side_state  (server_side_state),
		.packet_direction   (packet_direction),
		.last_fin_direction (last_fin_direction)
	);

endmodule

`default_nettype wire
